>>> rtl/femmsr_pkg.sv
package femmsr_pkg;

    localparam int MAX_DIVISIONS = 255;
    localparam int DW = 10;                       // divisions width (holds MAX_DIVISIONS + 1)
    localparam int NODE_W = 2 * DW;                // node count / slot width
    localparam int POS_W = 19;
    localparam int VAL_W = 48;
    localparam int A_W = 16;                       // sum of w*(5j+c), signed
    localparam int SUM_W = 64;

    localparam logic [1:0] KIND_DIAG = 2'd0;
    localparam logic [1:0] KIND_OFF  = 2'd1;
    localparam logic [1:0] KIND_TERM = 2'd2;

    localparam logic [1:0] REG_ANGLE  = 2'd0;
    localparam logic [1:0] REG_RADIUS = 2'd1;
    localparam logic [1:0] REG_JAC    = 2'd2;
    localparam logic [1:0] REG_GROWTH = 2'd3;

    // Command from controller to datapath for one result beat.
    typedef struct packed {
        logic                  load;   // compute a value from a and w
        logic signed [A_W-1:0] a;
        logic [3:0]            w;
        logic [1:0]            kind;
        logic [POS_W-1:0]      pos;
        logic [POS_W-1:0]      idx;
        logic                  last;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_dp_status;

    function automatic logic [DW-1:0] eff_div(input logic [7:0] d);
        logic [DW-1:0] r;
        r = {{(DW-8){1'b0}}, d};
        if (d == 8'd0) r = DW'(1);
        else if (r > DW'(MAX_DIVISIONS)) r = DW'(MAX_DIVISIONS);
        return r;
    endfunction

endpackage

>>> rtl/femmsr_datapath.sv
module femmsr_datapath
    import femmsr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic signed [31:0]      i_jac,
    input  logic signed [31:0]      i_growth,
    input  t_cmd                    i_cmd,
    output t_dp_status              o_status,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [1:0]              o_kind,
    output logic [POS_W-1:0]        o_pos,
    output logic [POS_W-1:0]        o_idx,
    output logic signed [VAL_W-1:0] o_val,
    output logic                    o_last
);
    // Steps: 0 S = G*A + 5W<<30; 1 split |S| and |J|; 2 lo*|J|; 3 hi*|J|; 4 round/saturate.
    logic [2:0]              r_step, n_step;
    logic signed [SUM_W-1:0] r_s;
    logic                    r_neg;
    logic [63:0]             r_us, r_plo, r_phi;
    logic [31:0]             r_uj;
    t_cmd                    r_cmd;
    logic                    r_valid;
    logic [1:0]              r_kind;
    logic [POS_W-1:0]        r_pos, r_idx;
    logic signed [VAL_W-1:0] r_val;
    logic                    r_last;

    logic [63:0] w_q, w_lim;
    logic [VAL_W-1:0] w_mag;

    assign w_q = ((r_plo + 64'd536870912) >> 30) + (r_phi << 2);
    assign w_lim = r_neg ? (64'd1 << 47) : ((64'd1 << 47) - 64'd1);
    assign w_mag = (w_q > w_lim) ? w_lim[VAL_W-1:0] : w_q[VAL_W-1:0];

    always_comb begin
        n_step = r_step;
        if (r_step == 3'd0 && i_cmd.load) n_step = 3'd1;
        else if (r_step >= 3'd1 && r_step <= 3'd3) n_step = r_step + 3'd1;
        else if (r_step == 3'd4 && (!r_valid || i_ready)) n_step = 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (o_valid && i_ready) r_valid <= 1'b0;
            if (r_step == 3'd4 && (!r_valid || i_ready)) r_valid <= 1'b1;
        end
        if (r_step == 3'd0 && i_cmd.load) begin
            r_cmd <= i_cmd;
            r_s <= SUM_W'(i_growth) * SUM_W'(i_cmd.a)
                 + (SUM_W'(5 * i_cmd.w) <<< 30);
        end
        if (r_step == 3'd1) begin
            r_neg <= i_jac[31] != r_s[SUM_W-1];
            r_us <= r_s[SUM_W-1] ? 64'(-r_s) : 64'(r_s);
            r_uj <= i_jac[31] ? 32'(-i_jac) : 32'(i_jac);
        end
        if (r_step == 3'd2) r_plo <= {32'd0, r_us[31:0]} * {32'd0, r_uj};
        if (r_step == 3'd3) r_phi <= {32'd0, r_us[63:32]} * {32'd0, r_uj};
        if (r_step == 3'd4 && (!r_valid || i_ready)) begin
            r_kind <= r_cmd.kind;
            r_pos <= r_cmd.pos;
            r_idx <= r_cmd.idx;
            r_last <= r_cmd.last;
            if (r_cmd.kind == KIND_TERM) r_val <= '0;
            else r_val <= r_neg ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_status.busy = r_step != 3'd0;
    assign o_status.done = r_step == 3'd4 && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_pos = r_pos;
    assign o_idx = r_idx;
    assign o_val = r_val;
    assign o_last = r_last;
endmodule

>>> rtl/femmsr_controller.sv
module femmsr_controller
    import femmsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ai,
    input  logic [7:0]  i_rj,
    input  t_dp_status  i_status,
    output t_cmd        o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]        r_state;
    logic [7:0]        r_adiv, r_rdiv;
    logic [NODE_W-1:0] r_slot, r_base;
    logic [DW-1:0]     r_i, r_j;
    logic [2:0]        r_cls;   // node class
    logic [2:0]        r_cnt, r_e;   // r_e: 0 diag, 1..cnt off, cnt+1 term
    logic              r_term;

    logic [DW-1:0] w_m, w_n, w_w;
    logic [NODE_W-1:0] w_nodes;

    assign w_m = eff_div(r_adiv);
    assign w_n = eff_div(r_rdiv);
    assign w_w = w_n + DW'(1);
    assign w_nodes = NODE_W'(w_m + DW'(1)) * NODE_W'(w_w);

    localparam logic [2:0] C_00 = 3'd0, C_0N = 3'd1, C_M0 = 3'd2, C_MN = 3'd3,
                           C_M = 3'd4, C_I0 = 3'd5, C_J0 = 3'd6, C_IN = 3'd7;
    // interior is encoded by r_int
    logic r_int;

    assign o_ready = r_state == S_IDLE;

    // pair term: w*(5j+c) with j selected per entry
    logic signed [A_W-1:0] a5, ap, am;   // 5j, 5(j+1)... helpers
    logic signed [31:0]    w_a;
    logic [3:0]            w_wt;
    logic [31:0]           w_col;
    logic [NODE_W-1:0]     w_rowm1, w_row, w_rowp1;

    assign a5 = A_W'(5) * $signed({1'b0, r_j});
    assign w_rowm1 = NODE_W'(r_i - DW'(1)) * NODE_W'(w_w);
    assign w_row = NODE_W'(r_i) * NODE_W'(w_w);
    assign w_rowp1 = w_row + NODE_W'(w_w);
    assign ap = a5 + A_W'(5);
    assign am = a5 - A_W'(5);

    // Sums per entry. Equal-type pairs weigh 2. Pair(t1,t2) with arg x: 5x+c.
    always_comb begin
        w_a = '0; w_wt = 4'd0; w_col = '0;
        if (r_int) begin
            unique case (r_e)
                3'd0: begin w_a = 2*(a5+1) + 2*(ap-3) + 2*(a5+1) + 2*(a5-1) + 2*(am+3)
                              + 2*(a5-1); w_wt = 4'd12; end
                3'd1: begin w_a = (a5-2) + (am+2); w_wt = 4'd2; w_col = w_rowm1 + NODE_W'(r_j) - 1; end
                3'd2: begin w_a = (a5+1) + (a5-1); w_wt = 4'd2; w_col = w_rowm1 + NODE_W'(r_j); end
                3'd3: begin w_a = (am+2) + (a5-2); w_wt = 4'd2; w_col = w_row + NODE_W'(r_j) - 1; end
                3'd4: begin w_a = (a5+2) + (ap-2); w_wt = 4'd2; w_col = w_row + NODE_W'(r_j) + 1; end
                3'd5: begin w_a = (a5+1) + (a5-1); w_wt = 4'd2; w_col = w_rowp1 + NODE_W'(r_j); end
                3'd6: begin w_a = (ap-2) + (a5+2); w_wt = 4'd2; w_col = w_rowp1 + NODE_W'(r_j) + 1; end
                default: ;
            endcase
        end else begin
            unique case (r_cls)
                C_00: unique case (r_e)
                    3'd0: begin w_a = 2*A_W'(2) + 2*A_W'(1); w_wt = 4'd4; end
                    3'd1: begin w_a = A_W'(3); w_wt = 4'd1; w_col = NODE_W'(1); end
                    3'd2: begin w_a = A_W'(1); w_wt = 4'd1; w_col = NODE_W'(w_w); end
                    3'd3: begin w_a = A_W'(5); w_wt = 4'd2; w_col = NODE_W'(w_w) + 1; end
                    default: ;
                endcase
                C_0N: unique case (r_e)
                    3'd0: begin w_a = 2*(a5-1); w_wt = 4'd2; end
                    3'd1: begin w_a = a5-2; w_wt = 4'd1; w_col = NODE_W'(w_n) - 1; end
                    3'd2: begin w_a = a5-1; w_wt = 4'd1; w_col = NODE_W'(w_w) + NODE_W'(w_n); end
                    default: ;
                endcase
                C_M0: unique case (r_e)
                    3'd0: begin w_a = A_W'(2); w_wt = 4'd2; end
                    3'd1: begin w_a = A_W'(1); w_wt = 4'd1; w_col = w_rowm1; end
                    3'd2: begin w_a = A_W'(2); w_wt = 4'd1; w_col = w_row + 1; end
                    default: ;
                endcase
                C_MN: unique case (r_e)
                    3'd0: begin w_a = 2*(a5-1) + 2*(am+3); w_wt = 4'd4; end
                    3'd1: begin w_a = (a5-2) + (am+2); w_wt = 4'd2; w_col = w_rowm1 + NODE_W'(r_j) - 1; end
                    3'd2: begin w_a = a5-1; w_wt = 4'd1; w_col = w_rowm1 + NODE_W'(r_j); end
                    3'd3: begin w_a = am+2; w_wt = 4'd1; w_col = w_row + NODE_W'(r_j) - 1; end
                    default: ;
                endcase
                C_M: unique case (r_e)
                    3'd0: begin w_a = 2*(a5+1) + 2*(a5-1) + 2*(am+3); w_wt = 4'd6; end
                    3'd1: begin w_a = (a5-2) + (am+2); w_wt = 4'd2; w_col = w_rowm1 + NODE_W'(r_j) - 1; end
                    3'd2: begin w_a = (a5+1) + (a5-1); w_wt = 4'd2; w_col = w_rowm1 + NODE_W'(r_j); end
                    3'd3: begin w_a = am+2; w_wt = 4'd1; w_col = w_row + NODE_W'(r_j) - 1; end
                    3'd4: begin w_a = a5+2; w_wt = 4'd1; w_col = w_row + NODE_W'(r_j) + 1; end
                    default: ;
                endcase
                C_I0: unique case (r_e)   // row 0, inner column
                    3'd0: begin w_a = 2*(ap-3) + 2*(a5+1) + 2*(a5-1); w_wt = 4'd6; end
                    3'd1: begin w_a = a5-2; w_wt = 4'd1; w_col = NODE_W'(r_j) - 1; end
                    3'd2: begin w_a = ap-2; w_wt = 4'd1; w_col = NODE_W'(r_j) + 1; end
                    3'd3: begin w_a = (a5+1) + (a5-1); w_wt = 4'd2; w_col = NODE_W'(w_w) + NODE_W'(r_j); end
                    3'd4: begin w_a = (ap-2) + (a5+2); w_wt = 4'd2; w_col = NODE_W'(w_w) + NODE_W'(r_j) + 1; end
                    default: ;
                endcase
                C_J0: unique case (r_e)   // column 0, inner row
                    3'd0: begin w_a = A_W'(2) + 2*A_W'(2) + 2*A_W'(1); w_wt = 4'd6; end
                    3'd1: begin w_a = A_W'(1); w_wt = 4'd1; w_col = w_rowm1; end
                    3'd2: begin w_a = A_W'(2) + A_W'(3); w_wt = 4'd2; w_col = w_row + 1; end
                    3'd3: begin w_a = A_W'(1); w_wt = 4'd1; w_col = w_rowp1; end
                    3'd4: begin w_a = A_W'(5); w_wt = 4'd2; w_col = w_rowp1 + 1; end
                    default: ;
                endcase
                default: unique case (r_e)  // column N, inner row
                    3'd0: begin w_a = 2*(a5-1) + 2*(am+3) + 2*(a5-1); w_wt = 4'd6; end
                    3'd1: begin w_a = (a5-2) + (am+2); w_wt = 4'd2; w_col = w_rowm1 + NODE_W'(r_j) - 1; end
                    3'd2: begin w_a = a5-1; w_wt = 4'd1; w_col = w_rowm1 + NODE_W'(r_j); end
                    3'd3: begin w_a = (am+2) + (a5-2); w_wt = 4'd2; w_col = w_row + NODE_W'(r_j) - 1; end
                    3'd4: begin w_a = a5-1; w_wt = 4'd1; w_col = w_rowp1 + NODE_W'(r_j); end
                    default: ;
                endcase
            endcase
        end
    end

    logic w_is_term, w_is_last;
    assign w_is_term = r_e == r_cnt + 3'd1;
    assign w_is_last = r_term ? w_is_term : (r_e == r_cnt);

    always_comb begin
        o_cmd = '0;
        o_cmd.load = r_state == S_ISSUE;
        o_cmd.a = A_W'(w_a);
        o_cmd.w = w_wt;
        o_cmd.last = w_is_last;
        if (r_e == 3'd0) begin
            o_cmd.kind = KIND_DIAG;
            o_cmd.pos = POS_W'(r_base);
            o_cmd.idx = POS_W'(r_slot);
        end else if (w_is_term) begin
            o_cmd.kind = KIND_TERM;
            o_cmd.pos = POS_W'(w_nodes);
            o_cmd.idx = POS_W'(r_slot + NODE_W'(r_cnt));
        end else begin
            o_cmd.kind = KIND_OFF;
            o_cmd.pos = POS_W'(r_slot + NODE_W'(r_e) - 1);
            o_cmd.idx = POS_W'(w_col);
        end
    end

    logic [DW-1:0] w_ai, w_rj;
    assign w_ai = DW'(i_ai);
    assign w_rj = DW'(i_rj);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_adiv <= 8'd1;
            r_rdiv <= 8'd1;
            r_slot <= NODE_W'(5);
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_ANGLE) r_adiv <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == REG_RADIUS) r_rdiv <= i_cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && w_ai <= w_m && w_rj <= w_n) begin
                        r_i <= w_ai; r_j <= w_rj; r_e <= 3'd0;
                        r_base <= NODE_W'(w_ai) * NODE_W'(w_w) + NODE_W'(w_rj);
                        r_term <= w_ai == w_m && w_rj == w_n;
                        r_int <= 1'b0;
                        if (w_ai == 0 && w_rj == 0) begin
                            r_cls <= C_00; r_cnt <= 3'd3; r_slot <= w_nodes + NODE_W'(1);
                        end else if (w_ai == 0 && w_rj == w_n) begin
                            r_cls <= C_0N; r_cnt <= 3'd2;
                        end else if (w_ai == w_m && w_rj == 0) begin
                            r_cls <= C_M0; r_cnt <= 3'd2;
                        end else if (w_ai == w_m && w_rj == w_n) begin
                            r_cls <= C_MN; r_cnt <= 3'd3;
                        end else if (w_ai == w_m) begin
                            r_cls <= C_M; r_cnt <= 3'd4;
                        end else if (w_ai == 0) begin
                            r_cls <= C_I0; r_cnt <= 3'd4;
                        end else if (w_rj == 0) begin
                            r_cls <= C_J0; r_cnt <= 3'd4;
                        end else if (w_rj == w_n) begin
                            r_cls <= C_IN; r_cnt <= 3'd4;
                        end else begin
                            r_cls <= C_IN; r_cnt <= 3'd6; r_int <= 1'b1;
                        end
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: if (!i_status.busy) r_state <= S_WAIT;
                S_WAIT: begin
                    if (i_status.done) begin
                        if (w_is_last) begin
                            r_slot <= r_slot + NODE_W'(r_cnt);
                            r_state <= S_IDLE;
                        end else begin
                            r_e <= r_e + 3'd1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/fem_mass_matrix_msr_row_assembler.sv
// Emits one node's row of the ring-mesh mass matrix in modified sparse row form:
// a diagonal beat with the row pointer, two to six off-diagonal beats with column
// node numbers, and after the last corner node a terminating pointer beat
// (tlast marks the node's final beat). Nodes outside the grid are taken and
// dropped. One node at a time: each beat passes in order through the shared
// arithmetic (issue with the 32x16 product G*A, sign split of S and J, two
// 32x32 partial products of J*S, then round, saturate and load the output
// register); a beat held in the output register stalls the next one in its
// round step.
// Registers (write at i_cfg_we): 0 angle divisions, 1 radius divisions,
// 2 jacobian scale Q30, 3 growth step Q30; zero divisions count as one.
module fem_mass_matrix_msr_row_assembler
    import femmsr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // angle_index[7:0], radius_index[15:8]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [87:0]  m_axis_tdata,   // position[18:0], index_word[37:19], entry_value[85:38]
    output logic [1:0]   m_axis_tuser,   // entry_kind
    output logic         m_axis_tlast
);
    logic signed [31:0] r_jac, r_growth;
    t_cmd w_cmd;
    t_dp_status w_status;
    logic [POS_W-1:0] w_pos, w_idx;
    logic signed [VAL_W-1:0] w_val;

    // Hold the Q30 coefficients here; divisions live in the controller.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jac <= '0;
            r_growth <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_JAC) r_jac <= i_cfg_data;
            if (i_cfg_idx == REG_GROWTH) r_growth <= i_cfg_data;
        end
    end

    femmsr_controller u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx,
        .i_cfg_data(i_cfg_data[7:0]),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_ai(s_axis_tdata[7:0]), .i_rj(s_axis_tdata[15:8]),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    femmsr_datapath u_dp (
        .i_clk, .i_rst_n, .i_jac(r_jac), .i_growth(r_growth),
        .i_cmd(w_cmd), .o_status(w_status),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_kind(m_axis_tuser), .o_pos(w_pos), .o_idx(w_idx),
        .o_val(w_val), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_val, w_idx, w_pos};
endmodule

>>> dv/fem_mass_matrix_msr_row_assembler_tb.sv
`timescale 1ns / 100ps

module fem_mass_matrix_msr_row_assembler_tb;
    import femmsr_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [18:0] pos;
        logic [18:0] idx;
        logic [47:0] val;
        logic        last;
    } t_msr_beat;

    // one row of the directed table; typed rows carry the diagonal's slot and pointer
    typedef struct {
        logic [7:0]  ai;
        logic [7:0]  ri;
        bit          typed;
        logic [18:0] pos;
        logic [18:0] idx;
    } t_node_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;   // angle_index[7:0], radius_index[15:8]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;   // position[18:0], index_word[37:19], entry_value[85:38]
    logic [1:0]   m_axis_tuser;   // entry_kind
    logic         m_axis_tlast;

    // shadow copy of the register file and the slot counter
    logic [7:0]         sh_angle;
    logic [7:0]         sh_radius;
    logic signed [31:0] sh_jac;
    logic signed [31:0] sh_growth;
    logic [19:0]        slot_cnt;

    t_msr_beat row_beats[$];
    int        mismatches;
    int        node_count;
    int        idle_mode;
    int        new_beats;   // beats queued by the latest accepted node

    // per-entry sums: entry 0 is the diagonal, 1..6 the off-diagonals
    longint sum_a[7];
    longint sum_w[7];
    int     col_no[7];

    int pair_c[6][6] = '{
        '{-1, -2, -1, 0, 0, 0},
        '{-2, -3, -2, 0, 0, 0},
        '{-1, -2, -1, 0, 0, 0},
        '{0, 0, 0, 1, 2, 1},
        '{0, 0, 0, 2, 3, 2},
        '{0, 0, 0, 1, 2, 1}
    };

    fem_mass_matrix_msr_row_assembler i_dut (.*);

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Clamp a division register into 1..MAX_DIVISIONS.
    function automatic int clamp_div(logic [7:0] d);
        int v;
        v = d;
        if (v == 0) v = 1;
        if (v > MAX_DIVISIONS) v = MAX_DIVISIONS;
        return v;
    endfunction

    function automatic void add_pair(int e, int t1, int t2, longint jj);
        longint wt;
        wt = (t1 == t2) ? 2 : 1;
        sum_a[e] += wt * (5 * jj + pair_c[t1-1][t2-1]);
        sum_w[e] += wt;
    endfunction

    // J * (G*A + 5*W*2^30) / 2^30, round half away from zero, saturate to 48 bits
    function automatic logic [47:0] gram_value(longint a, longint w);
        longint      s;
        longint      jv;
        bit          neg;
        logic [127:0] mag_j, mag_s, q, lim;
        jv = sh_jac;
        s = longint'(sh_growth) * a + 5 * w * (longint'(1) << 30);
        neg = (jv < 0) != (s < 0);
        mag_j = (jv < 0) ? 128'(-jv) : 128'(jv);
        mag_s = (s < 0) ? 128'(-s) : 128'(s);
        q = (mag_j * mag_s + (128'd1 << 29)) >> 30;
        lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
        if (q > lim) q = lim;
        return neg ? 48'(-q) : q[47:0];
    endfunction

    // Build the expected beats of one accepted node and advance the slot counter.
    function automatic void predict_row(int i, int j);
        int m, n, w, nodes, cnt, q0;
        longint jj, nn;
        t_msr_beat b;
        new_beats = 0;
        m = clamp_div(sh_angle);
        n = clamp_div(sh_radius);
        w = n + 1;
        nodes = (m + 1) * w;
        jj = j;
        nn = n;
        if (i > m || j > n) return;   // off the grid: drop, no state change
        for (int e = 0; e < 7; e++) begin
            sum_a[e] = 0;
            sum_w[e] = 0;
            col_no[e] = 0;
        end
        if (i == 0 && j == 0) begin
            slot_cnt = 20'(nodes + 1);
            add_pair(0, 2, 2, 1); add_pair(0, 6, 6, 0);
            add_pair(1, 2, 1, 1); col_no[1] = 1;
            add_pair(2, 6, 4, 0); col_no[2] = w;
            add_pair(3, 2, 3, 1); add_pair(3, 6, 5, 0); col_no[3] = w + 1;
            cnt = 3;
        end else if (i == 0 && j == n) begin
            add_pair(0, 1, 1, nn);
            add_pair(1, 1, 2, nn); col_no[1] = n - 1;
            add_pair(2, 1, 3, nn); col_no[2] = w + n;
            cnt = 2;
        end else if (i == m && j == 0) begin
            add_pair(0, 4, 4, 0);
            add_pair(1, 4, 6, 0); col_no[1] = (m - 1) * w;
            add_pair(2, 4, 5, 0); col_no[2] = m * w + 1;
            cnt = 2;
        end else if (i == m && j == n) begin
            add_pair(0, 3, 3, nn); add_pair(0, 5, 5, nn - 1);
            add_pair(1, 2, 3, nn); add_pair(1, 6, 5, nn - 1); col_no[1] = (m - 1) * w + n - 1;
            add_pair(2, 1, 3, nn); col_no[2] = col_no[1] + 1;
            add_pair(3, 5, 4, nn - 1); col_no[3] = m * w + n - 1;
            cnt = 3;
        end else if (i == m) begin
            add_pair(0, 4, 4, jj); add_pair(0, 3, 3, jj); add_pair(0, 5, 5, jj - 1);
            add_pair(1, 3, 2, jj); add_pair(1, 5, 6, jj - 1); col_no[1] = (m - 1) * w + j - 1;
            add_pair(2, 4, 6, jj); add_pair(2, 3, 1, jj); col_no[2] = col_no[1] + 1;
            add_pair(3, 5, 4, jj - 1); col_no[3] = m * w + j - 1;
            add_pair(4, 4, 5, jj); col_no[4] = col_no[3] + 2;
            cnt = 4;
        end else if (i == 0) begin
            add_pair(0, 2, 2, jj + 1); add_pair(0, 6, 6, jj); add_pair(0, 1, 1, jj);
            add_pair(1, 1, 2, jj); col_no[1] = j - 1;
            add_pair(2, 2, 1, jj + 1); col_no[2] = j + 1;
            add_pair(3, 6, 4, jj); add_pair(3, 1, 3, jj); col_no[3] = w + j;
            add_pair(4, 2, 3, jj + 1); add_pair(4, 6, 5, jj); col_no[4] = w + j + 1;
            cnt = 4;
        end else if (j == 0) begin
            add_pair(0, 4, 4, 0); add_pair(0, 2, 2, 1); add_pair(0, 6, 6, 0);
            add_pair(1, 4, 6, 0); col_no[1] = (i - 1) * w;
            add_pair(2, 4, 5, 0); add_pair(2, 2, 1, 1); col_no[2] = i * w + 1;
            add_pair(3, 6, 4, 0); col_no[3] = (i + 1) * w;
            add_pair(4, 2, 3, 1); add_pair(4, 6, 5, 0); col_no[4] = col_no[3] + 1;
            cnt = 4;
        end else if (j == n) begin
            add_pair(0, 3, 3, nn); add_pair(0, 5, 5, nn - 1); add_pair(0, 1, 1, nn);
            add_pair(1, 3, 2, nn); add_pair(1, 5, 6, nn - 1); col_no[1] = (i - 1) * w + n - 1;
            add_pair(2, 3, 1, nn); col_no[2] = col_no[1] + 1;
            add_pair(3, 5, 4, nn - 1); add_pair(3, 1, 2, nn); col_no[3] = i * w + n - 1;
            add_pair(4, 1, 3, nn); col_no[4] = (i + 1) * w + n;
            cnt = 4;
        end else begin
            add_pair(0, 4, 4, jj); add_pair(0, 2, 2, jj + 1); add_pair(0, 6, 6, jj);
            add_pair(0, 1, 1, jj); add_pair(0, 5, 5, jj - 1); add_pair(0, 3, 3, jj);
            add_pair(1, 3, 2, jj); add_pair(1, 5, 6, jj - 1); col_no[1] = (i - 1) * w + j - 1;
            add_pair(2, 4, 6, jj); add_pair(2, 3, 1, jj); col_no[2] = col_no[1] + 1;
            add_pair(3, 5, 4, jj - 1); add_pair(3, 1, 2, jj); col_no[3] = i * w + j - 1;
            add_pair(4, 4, 5, jj); add_pair(4, 2, 1, jj + 1); col_no[4] = col_no[3] + 2;
            add_pair(5, 6, 4, jj); add_pair(5, 1, 3, jj); col_no[5] = (i + 1) * w + j;
            add_pair(6, 2, 3, jj + 1); add_pair(6, 6, 5, jj); col_no[6] = col_no[5] + 1;
            cnt = 6;
        end
        q0 = row_beats.size();
        b.kind = KIND_DIAG;
        b.pos = 19'(i * w + j);
        b.idx = slot_cnt[18:0];
        b.val = gram_value(sum_a[0], sum_w[0]);
        b.last = 1'b0;
        row_beats.push_back(b);
        for (int l = 1; l <= cnt; l++) begin
            b.kind = KIND_OFF;
            b.pos = 19'(slot_cnt + 20'(l - 1));
            b.idx = 19'(col_no[l]);
            b.val = gram_value(sum_a[l], sum_w[l]);
            row_beats.push_back(b);
        end
        slot_cnt = slot_cnt + 20'(cnt);
        if (i == m && j == n) begin
            b.kind = KIND_TERM;
            b.pos = 19'(nodes);
            b.idx = slot_cnt[18:0];
            b.val = '0;
            row_beats.push_back(b);
        end
        row_beats[row_beats.size() - 1].last = 1'b1;
        new_beats = row_beats.size() - q0;
        node_count++;
    endfunction

    // Receiver: stall at the rate of the current idle mode.
    always @(posedge i_clk) begin
        case (idle_mode)
            0: m_axis_tready <= ($urandom_range(0, 99) >= 79);
            1: m_axis_tready <= ($urandom_range(0, 99) >= 12);
            default: m_axis_tready <= 1'b1;
        endcase
    end

    // Compare every delivered beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_msr_beat exp_b;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (row_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: kind %0d pos %0d", m_axis_tuser,
                             m_axis_tdata[18:0]);
            end else begin
                exp_b = row_beats.pop_front();
                if (m_axis_tuser !== exp_b.kind || m_axis_tdata[18:0] !== exp_b.pos ||
                    m_axis_tdata[37:19] !== exp_b.idx || m_axis_tdata[85:38] !== exp_b.val ||
                    m_axis_tlast !== exp_b.last || m_axis_tdata[87:86] !== 2'b00) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp kind %0d pos %0d idx %0d val %h last %0d, got kind %0d pos %0d idx %0d val %h last %0d",
                                 exp_b.kind, exp_b.pos, exp_b.idx, exp_b.val, exp_b.last,
                                 m_axis_tuser, m_axis_tdata[18:0], m_axis_tdata[37:19],
                                 m_axis_tdata[85:38], m_axis_tlast);
                end
            end
        end
    end

    // Hold until every expected beat has come, then let the pipe drain.
    task automatic drain_rows();
        while (row_beats.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ANGLE:  sh_angle = data[7:0];
            REG_RADIUS: sh_radius = data[7:0];
            REG_JAC:    sh_jac = data;
            default:    sh_growth = data;
        endcase
    endtask

    task automatic write_all(logic [7:0] ad, logic [7:0] rd, logic [31:0] jac,
                             logic [31:0] grow);
        write_reg(REG_ANGLE, 32'(ad));
        write_reg(REG_RADIUS, 32'(rd));
        write_reg(REG_JAC, jac);
        write_reg(REG_GROWTH, grow);
    endtask

    // Offer one node beat, wait for the handshake, then maybe leave a gap.
    task automatic send_node(logic [7:0] ai, logic [7:0] ri);
        int gap;
        idle_mode = (node_count < 160) ? 0 : (node_count < 320) ? 1 : 2;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ri, ai};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_row(ai, ri);
        gap = 0;
        if (idle_mode == 0 && $urandom_range(0, 99) < 12) gap = $urandom_range(1, 4);
        if (idle_mode == 1 && $urandom_range(0, 99) < 79) gap = $urandom_range(1, 6);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_q30();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h4000_0000;
            3: return 32'(-($urandom_range(0, 32'h3FFF_FFFF)));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_div();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom);
            default: return 8'($urandom_range(1, 6));
        endcase
    endfunction

    t_node_row dir_rows[23] = '{
        // reset setting (2 x 2 grid, zero jacobian): slots read off by hand
        '{8'd0, 8'd0, 1'b1, 19'd0, 19'd5},
        '{8'd0, 8'd1, 1'b1, 19'd1, 19'd8},
        '{8'd1, 8'd0, 1'b1, 19'd2, 19'd10},
        '{8'd1, 8'd1, 1'b1, 19'd3, 19'd12},
        // off the grid, dropped
        '{8'd2, 8'd0, 1'b0, 19'd0, 19'd0},
        '{8'd0, 8'd2, 1'b0, 19'd0, 19'd0},
        '{8'd255, 8'd255, 1'b0, 19'd0, 19'd0},
        // 3 x 4 grid: every node class
        '{8'd0, 8'd0, 1'b0, 19'd0, 19'd0}, '{8'd0, 8'd1, 1'b0, 19'd0, 19'd0},
        '{8'd0, 8'd2, 1'b0, 19'd0, 19'd0}, '{8'd0, 8'd3, 1'b0, 19'd0, 19'd0},
        '{8'd1, 8'd0, 1'b0, 19'd0, 19'd0}, '{8'd1, 8'd1, 1'b0, 19'd0, 19'd0},
        '{8'd1, 8'd2, 1'b0, 19'd0, 19'd0}, '{8'd1, 8'd3, 1'b0, 19'd0, 19'd0},
        '{8'd2, 8'd0, 1'b0, 19'd0, 19'd0}, '{8'd2, 8'd1, 1'b0, 19'd0, 19'd0},
        '{8'd2, 8'd2, 1'b0, 19'd0, 19'd0}, '{8'd2, 8'd3, 1'b0, 19'd0, 19'd0},
        // zero divisions act as one, extreme coefficients, nodes out of order
        '{8'd1, 8'd1, 1'b0, 19'd0, 19'd0}, '{8'd0, 8'd0, 1'b0, 19'd0, 19'd0},
        '{8'd1, 8'd0, 1'b0, 19'd0, 19'd0}, '{8'd0, 8'd1, 1'b0, 19'd0, 19'd0}
    };

    initial begin
        int m, n, first_b, start_cnt;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        sh_angle = 8'd1;
        sh_radius = 8'd1;
        sh_jac = '0;
        sh_growth = '0;
        slot_cnt = 20'd5;
        mismatches = 0;
        node_count = 0;
        idle_mode = 0;
        new_beats = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (r == 7) begin
                s_axis_tvalid <= 1'b0;
                drain_rows();
                write_all(8'd2, 8'd3, 32'h4000_0000, 32'hE000_0000);
            end
            if (r == 19) begin
                s_axis_tvalid <= 1'b0;
                drain_rows();
                write_all(8'd0, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF);
            end
            send_node(dir_rows[r].ai, dir_rows[r].ri);
            // typed rows: the diagonal slot and pointer are known, the value is zero
            if (dir_rows[r].typed && new_beats != 0) begin
                first_b = row_beats.size() - new_beats;
                row_beats[first_b].pos = dir_rows[r].pos;
                row_beats[first_b].idx = dir_rows[r].idx;
                row_beats[first_b].val = '0;
            end
        end

        // Random phases: a new setting while idle, then sweeps and noise.
        while (node_count < 480) begin
            s_axis_tvalid <= 1'b0;
            drain_rows();
            write_all(pick_div(), pick_div(), pick_q30(), pick_q30());
            m = clamp_div(sh_angle);
            n = clamp_div(sh_radius);
            start_cnt = node_count;
            while (node_count - start_cnt < 40 && node_count < 480) begin
                if ((m + 1) * (n + 1) <= 48 && $urandom_range(0, 3) != 0) begin
                    // well-formed sweep in row order
                    for (int i = 0; i <= m; i++)
                        for (int j = 0; j <= n; j++)
                            send_node(8'(i), 8'(j));
                end else begin
                    case ($urandom_range(0, 3))
                        0: send_node(8'($urandom), 8'($urandom));
                        1: send_node(8'(m), 8'(n));
                        2: send_node(8'd0, 8'd0);
                        default: send_node(8'($urandom_range(0, m)),
                                           8'($urandom_range(0, n)));
                    endcase
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        drain_rows();
        if (mismatches == 0 && row_beats.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
